// File: rtl/stereo_mean_abs_level_decimator_assert.svh
// ----------------------------------------------------------------------------
// Stereo mean level decimator assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_MEAN_ABS_LEVEL_DECIMATOR_ASSERT_SVH
`define STEREO_MEAN_ABS_LEVEL_DECIMATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SMALD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SMALD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/smald_pkg.sv
// ----------------------------------------------------------------------------
// Stereo mean level decimator package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package smald_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SPP_W       = 16;
    localparam int MH_W        = 8;
    localparam int HEIGHT_W    = 8;
    localparam int SUM_W       = SAMPLE_BITS - 1 + SPP_W + 1;
    localparam int NUM_W       = SUM_W + MH_W;
    localparam int DEN_W       = SAMPLE_BITS - 1 + SPP_W;
    localparam int Q_W         = HEIGHT_W;
    localparam int STEP_W      = $clog2(Q_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MH  = CFG_IDX_W'(1);

    localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(1600);
    localparam logic [MH_W-1:0]  MH_RESET  = MH_W'(20);

    typedef enum logic [1:0] {
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_RND
    } t_state;

    typedef struct packed {
        logic acc;
        logic close;
        logic load;
        logic step;
    } t_lane_ctrl;

endpackage

// File: rtl/stereo_mean_abs_level_decimator.sv
// ----------------------------------------------------------------------------
// Stereo mean absolute level decimator
// Averages stereo sample magnitudes into one waveform column per group.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      i_left_sample, i_right_sample
//  out       source     o_out_valid / i_out_stall    o_height_left, o_height_right
//  cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample pair is taken per cycle while a column fills.
// The closing pair starts a multiply step and a restoring divide per lane, then a
// rounding step, and input is stalled through all three.
// Rounding, with input stalled, waits while the output holds a stalled column.
// Reset is synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
module stereo_mean_abs_level_decimator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [smald_pkg::SAMPLE_BITS-1:0]  i_left_sample,
    input  logic [smald_pkg::SAMPLE_BITS-1:0]  i_right_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [smald_pkg::HEIGHT_W-1:0]     o_height_left,
    output logic [smald_pkg::HEIGHT_W-1:0]     o_height_right,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smald_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [smald_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import smald_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [SPP_W-1:0]    r_spp;
    logic [MH_W-1:0]     r_mh;
    logic [SPP_W-1:0]    r_count;
    logic [STEP_W-1:0]   r_step;

    logic [SPP_W-1:0]    spp_eff;
    logic [SPP_W-1:0]    n_count;
    logic                accept;
    logic                close;
    logic                free;
    logic                merge_load;
    t_lane_ctrl          ctrl;
    logic [HEIGHT_W-1:0] height_left;
    logic [HEIGHT_W-1:0] height_right;

    assign spp_eff    = (r_spp == '0) ? SPP_W'(1) : r_spp;
    assign n_count    = r_count + SPP_W'(1);
    assign close      = (n_count != '0) && (n_count >= spp_eff);
    assign accept     = i_in_valid && (r_state == ST_ACC);
    assign o_in_stall = (r_state != ST_ACC);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp <= SPP_RESET;
            r_mh  <= MH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPP: begin
                    r_spp <= i_cfg_data[SPP_W-1:0];
                end
                CFG_MH: begin
                    r_mh <= i_cfg_data[MH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= close ? '0 : n_count;
            end
            if (ctrl.load) begin
                r_step <= STEP_W'(Q_W - 1);
            end else if (ctrl.step) begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        ctrl.acc   = accept;
        ctrl.close = close;
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        merge_load = 1'b0;
        case (r_state)
            ST_ACC: begin
                if (accept && close) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                ctrl.load = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                ctrl.step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                if (free) begin
                    merge_load = 1'b1;
                    n_state    = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    smald_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_left_sample),
        .i_ctrl   (ctrl),
        .i_spp    (spp_eff),
        .i_mh     (r_mh),
        .o_height (height_left)
    );

    smald_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_right_sample),
        .i_ctrl   (ctrl),
        .i_spp    (spp_eff),
        .i_mh     (r_mh),
        .o_height (height_right)
    );

    smald_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (merge_load),
        .i_height_left  (height_left),
        .i_height_right (height_right),
        .i_out_stall    (i_out_stall),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .o_height_left  (o_height_left),
        .o_height_right (o_height_right)
    );

endmodule

// File: rtl/smald_lane.sv
// ----------------------------------------------------------------------------
// Stereo mean level decimator channel lane
// Accumulates sample magnitudes and divides the scaled sum into a height.
// ----------------------------------------------------------------------------
module smald_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [smald_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  smald_pkg::t_lane_ctrl              i_ctrl,
    input  logic [smald_pkg::SPP_W-1:0]        i_spp,
    input  logic [smald_pkg::MH_W-1:0]         i_mh,
    output logic [smald_pkg::HEIGHT_W-1:0]     o_height
);
    import smald_pkg::*;

    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_hold;
    logic [NUM_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_dvs;
    logic [DEN_W-1:0]       r_den;
    logic [Q_W-1:0]         r_q;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM_W-1:0]       n_sum;
    logic [NUM_W-1:0]       product;
    logic [DEN_W-1:0]       den_full;
    logic                   ge;
    logic [DEN_W:0]         twice_rem;
    logic [DEN_W:0]         den_ext;
    logic                   round_up;
    logic [Q_W:0]           rounded;

    assign mag      = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
    assign n_sum    = r_sum + SUM_W'(mag);
    assign product  = i_mh * r_hold;
    assign den_full = {i_spp, (SAMPLE_BITS-1)'(0)} - DEN_W'(i_spp);
    assign ge       = (r_rem >= r_dvs);

    assign twice_rem = {r_rem[DEN_W-1:0], 1'b0};
    assign den_ext   = {1'b0, r_den};
    assign round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && r_q[0]);
    assign rounded   = {1'b0, r_q} + (Q_W+1)'(round_up);
    assign o_height  = (rounded > {1'b0, i_mh}) ? i_mh : rounded[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.acc) begin
            r_sum <= i_ctrl.close ? '0 : n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc && i_ctrl.close) begin
            r_hold <= n_sum;
        end
        if (i_ctrl.load) begin
            r_rem <= product;
            r_den <= den_full;
            r_dvs <= NUM_W'(den_full) << (Q_W - 1);
            r_q   <= '0;
        end else if (i_ctrl.step) begin
            r_rem <= ge ? (r_rem - r_dvs) : r_rem;
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

endmodule

// File: rtl/smald_merge.sv
// ----------------------------------------------------------------------------
// Stereo mean level decimator merge stage
// Joins both lane heights into one registered output request.
// ----------------------------------------------------------------------------
module smald_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [smald_pkg::HEIGHT_W-1:0]  i_height_left,
    input  logic [smald_pkg::HEIGHT_W-1:0]  i_height_right,
    input  logic                            i_out_stall,
    output logic                            o_free,
    output logic                            o_out_valid,
    output logic [smald_pkg::HEIGHT_W-1:0]  o_height_left,
    output logic [smald_pkg::HEIGHT_W-1:0]  o_height_right
);
    import smald_pkg::*;

    logic                r_valid;
    logic [HEIGHT_W-1:0] r_left;
    logic [HEIGHT_W-1:0] r_right;

    assign o_free         = !r_valid || !i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_height_left  = r_left;
    assign o_height_right = r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= i_height_left;
            r_right <= i_height_right;
        end
    end

endmodule

// File: rtl/smald_checker.sv
// ----------------------------------------------------------------------------
// Stereo mean level decimator port checker
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
`include "stereo_mean_abs_level_decimator_assert.svh"

module smald_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [smald_pkg::HEIGHT_W-1:0]  o_height_left,
    input logic [smald_pkg::HEIGHT_W-1:0]  o_height_right
);
    import smald_pkg::*;

    `SMALD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_height_left) && $stable(o_height_right), "stalled output request changed")
    `SMALD_ASSERT_SAME(a_out_after_stall, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "column appeared without a divide phase")
    `SMALD_ASSERT_SAME(a_release_loads, i_clk, i_rst_n, $fell(o_in_stall), o_out_valid, "input released without a column")
    `SMALD_ASSERT_NEXT(a_divide_length, i_clk, i_rst_n, $rose(o_in_stall), o_in_stall, "divide phase ended too early")

endmodule

bind stereo_mean_abs_level_decimator smald_checker u_smald_checker (.*);
